FILE: hdl/brmc_pkg.sv
// Shared types, constants and register codes for the balance robot motor controller.
`default_nettype none
package brmc_pkg;

  // Controller limits
  localparam int unsigned PWM_PERIOD     = 3600;
  localparam int unsigned OUTPUT_LIMIT   = 1500;
  localparam int unsigned INTEGRAL_LIMIT = 2000;
  localparam int unsigned FALL_ANGLE_DEG = 80;

  // ceil(2^32 / 5): exact floor(x / 5) as (x * RECIP5) >> 32 for x < 2^30
  localparam logic [31:0] RECIP5 = 32'd858993460;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 24;

  typedef enum logic [CFG_AW-1:0] {
    REG_BALANCE_OFFSET  = 3'd0,
    REG_UPRIGHT_KP      = 3'd1,
    REG_UPRIGHT_KD      = 3'd2,
    REG_SPEED_KP        = 3'd3,
    REG_SPEED_KI        = 3'd4,
    REG_TURN_KP         = 3'd5,
    REG_TURN_KD         = 3'd6,
    REG_DEADBAND_OFFSET = 3'd7
  } brmc_reg_e;

  typedef struct packed {
    logic signed [16:0] balance_offset;
    logic signed [23:0] upright_kp;
    logic signed [23:0] upright_kd;
    logic signed [23:0] speed_kp;
    logic signed [23:0] speed_ki;
    logic signed [23:0] turn_kp;
    logic signed [23:0] turn_kd;
    logic        [10:0] deadband_offset;
  } brmc_cfg_t;

  typedef struct packed {
    logic signed [16:0] pitch_angle;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic signed [15:0] speed_target;
    logic signed [15:0] turn_target;
  } brmc_in_t;

  typedef struct packed {
    logic signed [11:0] drive_left;
    logic signed [11:0] drive_right;
    logic        [11:0] compare_left;
    logic               release_left;
    logic               direction_left;
    logic        [11:0] compare_right;
    logic               release_right;
    logic               direction_right;
    logic               fallen;
  } brmc_out_t;

  // Handshake between the top level and the sequencer
  typedef struct packed {
    logic start;     // input transfer this cycle
    logic out_free;  // result register can load
  } brmc_ctl_t;

  typedef struct packed {
    logic ready;     // sequencer idle
    logic done;      // result loads this cycle
  } brmc_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_P,
    ST_UP_D,
    ST_UP_SUM,
    ST_F1,
    ST_S,
    ST_F2,
    ST_INT,
    ST_SKP,
    ST_SKI,
    ST_TURN,
    ST_MIX,
    ST_OUT
  } brmc_step_e;

endpackage
`default_nettype wire

FILE: hdl/brmc_if.sv
// Valid/ready channel interfaces for control inputs and drive results.
`default_nettype none
interface brmc_in_if import brmc_pkg::*; ();
  logic     valid;
  logic     ready;
  brmc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface brmc_out_if import brmc_pkg::*; ();
  logic      valid;
  logic      ready;
  brmc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/brmc_cfg.sv
// Configuration register file with write-only port.
`default_nettype none
module brmc_cfg import brmc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  output brmc_cfg_t              cfg_o
);

  brmc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (brmc_reg_e'(cfg_idx_i))
        REG_BALANCE_OFFSET:  cfg_d.balance_offset  = cfg_data_i[16:0];
        REG_UPRIGHT_KP:      cfg_d.upright_kp      = cfg_data_i;
        REG_UPRIGHT_KD:      cfg_d.upright_kd      = cfg_data_i;
        REG_SPEED_KP:        cfg_d.speed_kp        = cfg_data_i;
        REG_SPEED_KI:        cfg_d.speed_ki        = cfg_data_i;
        REG_TURN_KP:         cfg_d.turn_kp         = cfg_data_i;
        REG_TURN_KD:         cfg_d.turn_kd         = cfg_data_i;
        REG_DEADBAND_OFFSET: cfg_d.deadband_offset = cfg_data_i[10:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.balance_offset  <= -17'sd461;
      cfg_q.upright_kp      <= 24'sd122880;
      cfg_q.upright_kd      <= -24'sd492;
      cfg_q.speed_kp        <= 24'sd32768;
      cfg_q.speed_ki        <= 24'sd164;
      cfg_q.turn_kp         <= -24'sd40960;
      cfg_q.turn_kd         <= 24'sd205;
      cfg_q.deadband_offset <= 11'd140;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hdl/brmc_mul.sv
// Shared signed 32x32 multiplier with registered product.
`default_nettype none
module brmc_mul import brmc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed      [63:0] p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

FILE: hdl/brmc_core.sv
// Sequencer and datapath: PD, filtered PI and turn terms over the shared multiplier.
`default_nettype none
module brmc_core import brmc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  brmc_cfg_t      cfg_i,
  input  brmc_ctl_t      ctl_i,
  input  brmc_in_t       item_i,
  output brmc_sts_t      sts_o,
  output brmc_out_t      result_o
);

  localparam logic signed [17:0] FALL_LIM  = 18'(FALL_ANGLE_DEG * 256);
  localparam logic signed [20:0] ILIM21    = 21'(INTEGRAL_LIMIT);
  localparam logic signed [11:0] ILIM12    = 12'(INTEGRAL_LIMIT);
  localparam logic signed [31:0] OLIM      = 32'(OUTPUT_LIMIT);
  localparam logic        [11:0] PERIOD12  = 12'(PWM_PERIOD);

  // Truncating signed shift (rounds toward zero)
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (v + bias) >>> sh;
  endfunction

  brmc_step_e step_q, step_d;
  brmc_in_t   in_q;

  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] up_q, up_d, sp_q, sp_d, tn_q, tn_d, a_q, a_d, b_q, b_d;
  logic signed [19:0] filt_q, filt_d;
  logic signed [11:0] integ_q, integ_d;
  logic               neg_q, neg_d;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  brmc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Operand prep
  logic signed [17:0] pitch18, ang_err, spd_err;
  logic signed [21:0] f4, f4_abs;
  logic signed [22:0] s5, s5_abs;
  logic        [19:0] quot;
  logic signed [19:0] quot_s;
  logic signed [20:0] integ_sum;
  logic signed [11:0] integ_clamp;
  logic               fallen;
  logic signed [63:0] up_sum, sp_sum;

  always_comb begin
    pitch18 = {in_q.pitch_angle[16], in_q.pitch_angle};
    ang_err = {cfg_i.balance_offset[16], cfg_i.balance_offset} - pitch18;
    spd_err = {{2{in_q.left_count[15]}}, in_q.left_count}
            + {{2{in_q.right_count[15]}}, in_q.right_count}
            - {{2{in_q.speed_target[15]}}, in_q.speed_target};
    f4      = {filt_q, 2'b00};
    f4_abs  = f4[21] ? -f4 : f4;
    s5      = ({{3{filt_q[19]}}, filt_q} <<< 2) + {{3{filt_q[19]}}, filt_q}
            + {{5{spd_err[17]}}, spd_err};
    s5_abs  = s5[22] ? -s5 : s5;
    quot    = prod[51:32];
    quot_s  = neg_q ? -$signed(quot) : $signed(quot);
    integ_sum = {{9{integ_q[11]}}, integ_q} + {filt_q[19], filt_q};
    if (integ_sum > ILIM21) begin
      integ_clamp = ILIM12;
    end else if (integ_sum < -ILIM21) begin
      integ_clamp = -ILIM12;
    end else begin
      integ_clamp = integ_sum[11:0];
    end
    fallen = (pitch18 >= FALL_LIM) || (pitch18 <= -FALL_LIM);
    up_sum = acc_q + (prod <<< 8);
    sp_sum = acc_q + prod;
  end

  // Final drive shaping
  logic signed [31:0] da, db, ca, cb;
  logic signed [11:0] drv_l, drv_r;
  logic        [11:0] mag_l, mag_r;

  always_comb begin
    da = a_q[31] ? a_q - {21'd0, cfg_i.deadband_offset} : a_q + {21'd0, cfg_i.deadband_offset};
    db = b_q[31] ? b_q - {21'd0, cfg_i.deadband_offset} : b_q + {21'd0, cfg_i.deadband_offset};
    ca = (da > OLIM) ? OLIM : ((da < -OLIM) ? -OLIM : da);
    cb = (db > OLIM) ? OLIM : ((db < -OLIM) ? -OLIM : db);
    drv_l = fallen ? 12'sd0 : ca[11:0];
    drv_r = fallen ? 12'sd0 : cb[11:0];
    mag_l = drv_l[11] ? 12'(-drv_l) : drv_l;
    mag_r = drv_r[11] ? 12'(-drv_r) : drv_r;
    result_o.drive_left      = drv_l;
    result_o.drive_right     = drv_r;
    result_o.compare_left    = PERIOD12 - mag_l;
    result_o.release_left    = (drv_l != 12'sd0);
    result_o.direction_left  = drv_l[11];
    result_o.compare_right   = PERIOD12 - mag_r;
    result_o.release_right   = (drv_r != 12'sd0);
    result_o.direction_right = !drv_r[11] && (drv_r != 12'sd0);
    result_o.fallen          = fallen;
  end

  // Sequencer
  always_comb begin
    step_d  = step_q;
    acc_d   = acc_q;
    up_d    = up_q;
    sp_d    = sp_q;
    tn_d    = tn_q;
    a_d     = a_q;
    b_d     = b_q;
    filt_d  = filt_q;
    integ_d = integ_q;
    neg_d   = neg_q;
    mul_a   = '0;
    mul_b   = '0;
    sts_o.ready = 1'b0;
    sts_o.done  = 1'b0;
    case (step_q)
      ST_IDLE: begin
        sts_o.ready = 1'b1;
        if (ctl_i.start) step_d = ST_UP_P;
      end
      ST_UP_P: begin
        mul_a  = {{8{cfg_i.upright_kp[23]}}, cfg_i.upright_kp};
        mul_b  = {{14{ang_err[17]}}, ang_err};
        step_d = ST_UP_D;
      end
      ST_UP_D: begin
        acc_d  = prod;
        mul_a  = {{8{cfg_i.upright_kd[23]}}, cfg_i.upright_kd};
        mul_b  = {{16{in_q.pitch_rate[15]}}, in_q.pitch_rate};
        step_d = ST_UP_SUM;
      end
      ST_UP_SUM: begin
        up_d   = 32'(trunc_shr(up_sum, 20));
        mul_a  = {{10{1'b0}}, f4_abs};
        mul_b  = RECIP5;
        neg_d  = f4[21];
        step_d = ST_F1;
      end
      ST_F1: begin
        filt_d = quot_s;
        step_d = ST_S;
      end
      ST_S: begin
        mul_a  = {{9{1'b0}}, s5_abs};
        mul_b  = RECIP5;
        neg_d  = s5[22];
        step_d = ST_F2;
      end
      ST_F2: begin
        filt_d = quot_s;
        step_d = ST_INT;
      end
      ST_INT: begin
        integ_d = integ_clamp;
        mul_a   = {{8{cfg_i.speed_kp[23]}}, cfg_i.speed_kp};
        mul_b   = {{12{filt_q[19]}}, filt_q};
        step_d  = ST_SKP;
      end
      ST_SKP: begin
        acc_d  = prod;
        mul_a  = {{8{cfg_i.speed_ki[23]}}, cfg_i.speed_ki};
        mul_b  = {{20{integ_q[11]}}, integ_q};
        step_d = ST_SKI;
      end
      ST_SKI: begin
        sp_d = 32'(trunc_shr(sp_sum, 12));
        if (fallen) integ_d = '0;  // used this tick, then dropped
        if (in_q.turn_target == 16'sd0) begin
          mul_a = {{8{cfg_i.turn_kd[23]}}, cfg_i.turn_kd};
          mul_b = {{16{in_q.yaw_rate[15]}}, in_q.yaw_rate};
        end else begin
          mul_a = {{8{cfg_i.turn_kp[23]}}, cfg_i.turn_kp};
          mul_b = {{16{in_q.turn_target[15]}}, in_q.turn_target};
        end
        step_d = ST_TURN;
      end
      ST_TURN: begin
        tn_d   = 32'(trunc_shr(prod, 12));
        step_d = ST_MIX;
      end
      ST_MIX: begin
        a_d    = up_q + sp_q + tn_q;
        b_d    = up_q + sp_q - tn_q;
        step_d = ST_OUT;
      end
      ST_OUT: begin
        if (ctl_i.out_free) begin
          sts_o.done = 1'b1;
          step_d     = ST_IDLE;
        end
      end
      default: step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_IDLE;
      filt_q  <= '0;
      integ_q <= '0;
    end else begin
      step_q  <= step_d;
      filt_q  <= filt_d;
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start && sts_o.ready) in_q <= item_i;
    acc_q <= acc_d;
    up_q  <= up_d;
    sp_q  <= sp_d;
    tn_q  <= tn_d;
    a_q   <= a_d;
    b_q   <= b_d;
    neg_q <= neg_d;
  end

  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= ILIM12) && (integ_q >= -ILIM12))
    else $error("speed integral beyond its limit");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.done |=> (step_q == ST_IDLE))
    else $error("sequencer not idle after result load");

endmodule
`default_nettype wire

FILE: hdl/balance_robot_motor_controller.sv
// Top level: two-wheel self-balancing cascade controller with one shared multiplier.
//
//  channel   dir  kind              width/notes
//  --------  ---  ----------------  -------------------------------------------
//  item_i    in   valid/ready       pitch, gyro rates, encoder counts, targets
//  result_o  out  valid/ready       drives, compares, release/direction, fallen
//  cfg_*     in   write-only regs   3-bit index, 24-bit data, no read-back
//
// Sequence: an item steps from UP_P to OUT between its transfer and the result
// register, the input is ready again on the next cycle and one item is in work at
// a time, paced by the seven products that share one registered 32x32 multiplier.
// Reset: gains return to defaults, filter and integral state clear, no result held.
// Stalls: a waiting result does not block the next transfer; only the final step
// of the following item holds until the result register is free.
`default_nettype none
module balance_robot_motor_controller import brmc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  brmc_in_if.sink                item_i,
  brmc_out_if.source             result_o
);

  brmc_cfg_t cfg;
  brmc_ctl_t ctl;
  brmc_sts_t sts;
  brmc_out_t res;

  logic      out_valid_q, out_valid_d;
  brmc_out_t out_data_q;

  brmc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input transfer only while the sequencer is idle
  assign item_i.ready = sts.ready;
  assign ctl.start    = item_i.valid && sts.ready;
  // Result register loads when empty or being drained this cycle
  assign ctl.out_free = !out_valid_q || result_o.ready;

  brmc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .ctl_i    (ctl),
    .item_i   (item_i.data),
    .sts_o    (sts),
    .result_o (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (sts.done) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sts.done) out_data_q <= res;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("input ready while an item is in work");

  a_fallen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.data.fallen) |->
      (result_o.data.drive_left == 12'sd0) && (result_o.data.drive_right == 12'sd0))
    else $error("drive nonzero while fallen");

  a_drive_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      (result_o.data.drive_left <= 12'sd1500) && (result_o.data.drive_left >= -12'sd1500) &&
      (result_o.data.drive_right <= 12'sd1500) && (result_o.data.drive_right >= -12'sd1500))
    else $error("drive beyond output limit");

endmodule
`default_nettype wire
